// ----- rtl/slot_period_speed_meter_core_macros.svh -----
// Assertion macros used by the speed meter core RTL file.
`ifndef SLOT_PERIOD_SPEED_METER_CORE_MACROS_SVH
`define SLOT_PERIOD_SPEED_METER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define SSPM_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sspm assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define SSPM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sspm assertion failed");
`else
`define SSPM_ASSERT(name, clk, rstn, prop)
`define SSPM_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/sspm_pkg.sv -----
// Package: widths and constants of the slot period speed meter.
package sspm_pkg;

  localparam int unsigned PERIOD_W  = 32;
  localparam int unsigned CIRC_W    = 16;
  localparam int unsigned SLOTS_W   = 8;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned USEC_PER_SEC = 1000000;
  // circumference * 1e6 fits in 36 bits
  localparam int unsigned NUMER_W = CIRC_W + 20;
  // average * slot count fits in 40 bits
  localparam int unsigned DENOM_W = PERIOD_W + SLOTS_W;

  localparam int unsigned AVG_DEPTH_DEF = 3;

  localparam logic [CIRC_W-1:0]  CIRC_RESET  = CIRC_W'(1000);
  localparam logic [SLOTS_W-1:0] SLOTS_RESET = SLOTS_W'(20);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIRC  = 1'b0,
    REG_SLOTS = 1'b1
  } cfg_reg_e;

endpackage

// ----- rtl/sspm_serial_div.sv -----
// Radix-2 restoring divider: one quotient bit per cycle.
module sspm_serial_div
  import sspm_pkg::*;
#(
  parameter int unsigned NUM_W = NUMER_W,
  parameter int unsigned DEN_W = DENOM_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] dvd_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, dvd_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ----- rtl/slot_period_speed_meter_core.sv -----
// Top level: moving-average tachometer, slot period in, wheel speed out.
//
// Usage:
// - Input channel (in_valid_i / in_ready_o / slot_period_us_i) carries one
//   slot-to-slot period in microseconds per transaction.
// - Output channel (out_valid_o / out_ready_i) returns one speed result per
//   input: speed_mm_per_s_o, clamped at 65535, and speed_saturated_o.
// - Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0: wheel circumference in mm, 1: slots per turn). Write while idle.
// - Each period enters a history of AVERAGE_DEPTH entries; the average is
//   sum / AVERAGE_DEPTH, speed = circumference * 1e6 / (average * slots).
//   A zero divisor gives speed 0, not saturated.
// - One shared radix-2 divider is used twice (average, then speed), with a
//   bit-serial slot-count multiplier between; the default depth is 3. A zero
//   divisor skips the second division.
// - One item is in flight at a time; the next is accepted once the result
//   sits in the output register, even while that result is still stalled.
// - Reset clears the history to zero, the write pointer, and loads the
//   registers with 1000 mm and 20 slots. No output is pending after reset.
// - A stalled receiver holds the output register; a finished result behind
//   it waits in the result hold stage and blocks the next item.
`include "slot_period_speed_meter_core_macros.svh"

module slot_period_speed_meter_core
  import sspm_pkg::*;
#(
  parameter int unsigned AVERAGE_DEPTH = AVG_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PERIOD_W-1:0]   slot_period_us_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SPEED_W-1:0]    speed_mm_per_s_o,
  output logic                  speed_saturated_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned PTR_W  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int unsigned SUM_W  = PERIOD_W + $clog2(AVERAGE_DEPTH);
  localparam int unsigned DIV_NW = (SUM_W > NUMER_W) ? SUM_W : NUMER_W;
  localparam int unsigned MCNT_W = $clog2(SLOTS_W + 1);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SUM      = 8'b0000_0010,
    ST_AVG_GO   = 8'b0000_0100,
    ST_AVG_WAIT = 8'b0000_1000,
    ST_MUL      = 8'b0001_0000,
    ST_DIV_GO   = 8'b0010_0000,
    ST_DIV_WAIT = 8'b0100_0000,
    ST_OUT      = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [CIRC_W-1:0]  circ_q;
  logic [SLOTS_W-1:0] slots_q;

  // period history
  logic [PERIOD_W-1:0] hist_q [AVERAGE_DEPTH];
  logic [PTR_W-1:0]    wptr_q;
  logic [PTR_W-1:0]    sum_idx_q;
  logic [SUM_W-1:0]    sum_q;

  // bit-serial multiplier
  logic [DENOM_W-1:0] mcand_q;
  logic [DENOM_W-1:0] prod_q;
  logic [SLOTS_W-1:0] mplier_q;
  logic [MCNT_W-1:0]  mul_cnt_q;

  // result hold and output register
  logic [SPEED_W-1:0] res_speed_q;
  logic               res_sat_q;
  logic               out_valid_q;
  logic [SPEED_W-1:0] out_speed_q;
  logic               out_sat_q;

  // shared divider
  logic               div_start;
  logic [DIV_NW-1:0]  div_num;
  logic [DENOM_W-1:0] div_den;
  logic               div_busy;
  logic               div_done;
  logic [DIV_NW-1:0]  div_quot;

  logic in_acc;
  logic out_load;
  logic div_sat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign div_sat    = (div_quot[DIV_NW-1:SPEED_W] != '0);

  // Operands: average first (sum / depth), then speed (circ * 1e6 / product).
  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_NW'(circ_q) * DIV_NW'(USEC_PER_SEC);
    div_den   = prod_q;
    case (state_q)
      ST_AVG_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(sum_q);
        div_den   = DENOM_W'(AVERAGE_DEPTH);
      end
      ST_DIV_GO: begin
        div_start = (prod_q != '0);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  sspm_serial_div #(
    .NUM_W (DIV_NW),
    .DEN_W (DENOM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_SUM;
      end
      ST_SUM: begin
        if (sum_idx_q == PTR_W'(AVERAGE_DEPTH - 1)) state_d = ST_AVG_GO;
      end
      ST_AVG_GO: begin
        state_d = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (div_done) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (mul_cnt_q == MCNT_W'(1)) state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        // zero divisor: skip the division, result is zero
        state_d = (prod_q != '0) ? ST_DIV_WAIT : ST_OUT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      circ_q      <= CIRC_RESET;
      slots_q     <= SLOTS_RESET;
      wptr_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < AVERAGE_DEPTH; i++) hist_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CIRC:  circ_q  <= cfg_wdata_i[CIRC_W-1:0];
          REG_SLOTS: slots_q <= cfg_wdata_i[SLOTS_W-1:0];
          default:   circ_q  <= circ_q;
        endcase
      end
      if (in_acc) begin
        hist_q[wptr_q] <= slot_period_us_i;
        wptr_q <= (wptr_q == PTR_W'(AVERAGE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sum_q     <= '0;
      sum_idx_q <= '0;
    end else if (state_q == ST_SUM) begin
      sum_q     <= sum_q + SUM_W'(hist_q[sum_idx_q]);
      sum_idx_q <= sum_idx_q + 1'b1;
    end

    if ((state_q == ST_AVG_WAIT) && div_done) begin
      mcand_q   <= DENOM_W'(div_quot[PERIOD_W-1:0]);
      mplier_q  <= slots_q;
      prod_q    <= '0;
      mul_cnt_q <= MCNT_W'(SLOTS_W);
    end else if (state_q == ST_MUL) begin
      if (mplier_q[0]) prod_q <= prod_q + mcand_q;
      mcand_q   <= {mcand_q[DENOM_W-2:0], 1'b0};
      mplier_q  <= {1'b0, mplier_q[SLOTS_W-1:1]};
      mul_cnt_q <= mul_cnt_q - 1'b1;
    end

    if ((state_q == ST_DIV_GO) && (prod_q == '0)) begin
      res_speed_q <= '0;
      res_sat_q   <= 1'b0;
    end else if ((state_q == ST_DIV_WAIT) && div_done) begin
      res_speed_q <= div_sat ? '1 : div_quot[SPEED_W-1:0];
      res_sat_q   <= div_sat;
    end

    if (out_load) begin
      out_speed_q <= res_speed_q;
      out_sat_q   <= res_sat_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign speed_mm_per_s_o  = out_speed_q;
  assign speed_saturated_o = out_sat_q;

  `SSPM_ASSERT(a_wptr_range, clk_i, rst_ni, wptr_q <= PTR_W'(AVERAGE_DEPTH - 1))
  `SSPM_ASSERT(a_div_start_idle, clk_i, rst_ni, !(div_start && div_busy))
  `SSPM_ASSERT_NEXT(a_accept_sum, clk_i, rst_ni, in_acc, state_q == ST_SUM)
  `SSPM_ASSERT_NEXT(a_done_only_waiting, clk_i, rst_ni, div_start,
                    div_busy && !div_done)
  `SSPM_ASSERT(a_sat_full_scale, clk_i, rst_ni,
               !out_valid_q || !out_sat_q || (out_speed_q == '1))

endmodule
